// File: hw/rtl/hkbl_pkg.sv
`timescale 1ns / 1ps
package hkbl_pkg;

   localparam int IndexDepth  = 2048;
   localparam int RecordDepth = 4096;
   localparam int IdxW        = $clog2(IndexDepth);
   localparam int RecW        = $clog2(RecordDepth);
   localparam int BoundW      = 13;
   localparam int SlotW       = 12;
   localparam int KeyW        = 160;

   localparam logic [1:0] CMD_LOAD_BOUND  = 2'd0;
   localparam logic [1:0] CMD_LOAD_RECORD = 2'd1;
   localparam logic [1:0] CMD_LOOKUP      = 2'd2;

   localparam logic [31:0] DIVISOR_RESET = 32'd524288;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [11:0] slot;
      logic [12:0] bound_value;
      logic [31:0] key_top;
      logic [63:0] key_mid;
      logic [63:0] key_low;
      logic [31:0] record_id;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [31:0] doc_id;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic capture;    // latch request, start divider
      logic div_step;   // one quotient bit
      logic rd_lo;      // read lower bound
      logic rd_hi;      // read upper bound
      logic set_range;  // register upper bound, start scan
      logic rd_rec;     // read record at scan pointer
      logic cmp;        // compare fetched record, advance pointer
      logic load_rsp;   // drive result into output register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic div_done;
      logic range_end;  // pointer has reached upper bound
      logic hit;        // fetched record matches
   } sts_type;

endpackage

// File: hw/rtl/hkbl_datapath.sv
`timescale 1ns / 1ps
module hkbl_datapath (
   input  logic              clock,
   input  logic              reset,
   input  hkbl_pkg::req_type req,
   input  logic              req_fire,
   input  logic [31:0]       divisor,
   input  hkbl_pkg::cmd_type ctl,
   output hkbl_pkg::sts_type sts,
   output hkbl_pkg::rsp_type rsp_result
);

   localparam int PtrW = hkbl_pkg::RecW + 1;
   localparam logic [PtrW-1:0] RecLimit = PtrW'(hkbl_pkg::RecordDepth);

   // memories
   logic [hkbl_pkg::BoundW-1:0] bound_mem [hkbl_pkg::IndexDepth];
   logic [hkbl_pkg::KeyW+31:0]  rec_mem   [hkbl_pkg::RecordDepth];

   logic [hkbl_pkg::BoundW-1:0] bound_rd_ff;
   logic [hkbl_pkg::KeyW+31:0]  rec_rd_ff;

   logic [hkbl_pkg::KeyW-1:0] key_ff;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [PtrW-1:0] ptr_ff, ptr_in;
   logic [PtrW-1:0] lo_ff, lo_in;
   logic [PtrW-1:0] hi_ff, hi_in;
   logic [hkbl_pkg::IdxW-1:0] bucket;
   logic [hkbl_pkg::IdxW-1:0] bound_addr;
   logic [PtrW-1:0] bound_sat;
   logic [32:0] trial;
   logic [28:0] kq;

   // load writes
   always_ff @(posedge clock) begin
      if (req_fire && req.cmd == hkbl_pkg::CMD_LOAD_BOUND &&
          32'(req.slot) < 32'(hkbl_pkg::IndexDepth)) begin
         bound_mem[req.slot[hkbl_pkg::IdxW-1:0]] <= req.bound_value;
      end
      if (req_fire && req.cmd == hkbl_pkg::CMD_LOAD_RECORD &&
          32'(req.slot) < 32'(hkbl_pkg::RecordDepth)) begin
         rec_mem[req.slot[hkbl_pkg::RecW-1:0]] <=
            {req.key_top, req.key_mid, req.key_low, req.record_id};
      end
   end

   // bucket from quotient, saturated
   assign kq = quo_ff[31:3];
   always_comb begin
      if (29'(kq) > 29'(hkbl_pkg::IndexDepth - 2)) begin
         bucket = hkbl_pkg::IdxW'(hkbl_pkg::IndexDepth - 2);
      end else begin
         bucket = kq[hkbl_pkg::IdxW-1:0];
      end
   end
   assign bound_addr = ctl.rd_hi ? bucket + 1'b1 : bucket;

   // registered memory reads
   always_ff @(posedge clock) begin
      if (ctl.rd_lo || ctl.rd_hi) begin
         bound_rd_ff <= bound_mem[bound_addr];
      end
      if (ctl.rd_rec) begin
         rec_rd_ff <= rec_mem[ptr_ff[hkbl_pkg::RecW-1:0]];
      end
   end

   // bound saturation at record depth
   always_comb begin
      if (PtrW'(bound_rd_ff) > RecLimit) begin
         bound_sat = RecLimit;
      end else begin
         bound_sat = PtrW'(bound_rd_ff);
      end
   end

   // restoring divider, one bit a cycle
   assign trial = {rem_ff, quo_ff[31]} - {1'b0, divisor};
   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      if (ctl.capture) begin
         rem_in = '0;
         quo_in = req.key_top;
         cnt_in = '0;
      end else if (ctl.div_step) begin
         if (divisor == '0) begin
            quo_in = '1;
            cnt_in = 6'd32;
         end else begin
            if (!trial[32]) begin
               rem_in = trial[31:0];
               quo_in = {quo_ff[30:0], 1'b1};
            end else begin
               rem_in = {rem_ff[30:0], quo_ff[31]};
               quo_in = {quo_ff[30:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   // scan range and pointer
   always_comb begin
      lo_in  = lo_ff;
      hi_in  = hi_ff;
      ptr_in = ptr_ff;
      if (ctl.rd_hi) begin
         lo_in = bound_sat;
      end
      if (ctl.set_range) begin
         hi_in  = bound_sat;
         ptr_in = lo_ff;
      end
      if (ctl.cmp) begin
         ptr_in = ptr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      ptr_ff <= ptr_in;
      if (ctl.capture) begin
         key_ff <= {req.key_top, req.key_mid, req.key_low};
      end
   end

   assign sts.div_done  = (cnt_ff == 6'd32);
   assign sts.range_end = (ptr_ff >= hi_ff);
   assign sts.hit       = (rec_rd_ff[hkbl_pkg::KeyW+31:32] == key_ff);

   // result for the output register
   always_comb begin
      rsp_result.doc_id = sts.hit ? rec_rd_ff[31:0] : 32'd0;
      rsp_result.found  = sts.hit && (rec_rd_ff[31:0] != 32'd0);
   end

endmodule

// File: hw/rtl/hkbl_ctrl.sv
`timescale 1ns / 1ps
module hkbl_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_fire,
   input  logic [1:0]        req_cmd,
   input  logic              rsp_busy,
   input  hkbl_pkg::sts_type sts,
   output hkbl_pkg::cmd_type ctl,
   output logic              idle
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DIV  = 3'd1;
   localparam logic [2:0] S_LO   = 3'd2;
   localparam logic [2:0] S_HI   = 3'd3;
   localparam logic [2:0] S_RNG  = 3'd4;
   localparam logic [2:0] S_FET  = 3'd5;
   localparam logic [2:0] S_CMP  = 3'd6;
   localparam logic [2:0] S_OUT  = 3'd7;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_fire && req_cmd == hkbl_pkg::CMD_LOOKUP) begin
               ctl.capture = 1'b1;
               state_in    = S_DIV;
            end
         end
         S_DIV: begin
            if (sts.div_done) begin
               state_in = S_LO;
            end else begin
               ctl.div_step = 1'b1;
            end
         end
         S_LO: begin
            ctl.rd_lo = 1'b1;
            state_in  = S_HI;
         end
         S_HI: begin
            ctl.rd_hi = 1'b1;
            state_in  = S_RNG;
         end
         S_RNG: begin
            ctl.set_range = 1'b1;
            state_in      = S_FET;
         end
         S_FET: begin
            if (sts.range_end) begin
               state_in = S_OUT;
            end else begin
               ctl.rd_rec = 1'b1;
               state_in   = S_CMP;
            end
         end
         S_CMP: begin
            if (sts.hit) begin
               state_in = S_OUT;
            end else begin
               ctl.cmp  = 1'b1;
               state_in = S_FET;
            end
         end
         S_OUT: begin
            // miss: the fetched record may still be stale, forced to no hit at the output register
            if (!rsp_busy) begin
               ctl.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign idle = (state_ff == S_IDLE);

endmodule

// File: hw/rtl/hashed_key_bucket_lookup.sv
`timescale 1ns / 1ps
// channel  ports                          direction  carries
// request  req_valid req_stall req_data    in         load or lookup request
// result   rsp_valid rsp_stall rsp_data    out        found flag and doc id
// csr      csr_valid csr_ready csr_data    in         bucket divisor
//
// a load is written into its memory when it is taken; a lookup runs the bit-serial
// divider, reads the lower and upper bounds, then fetches and compares one record at
// a time through the single record memory port until a match or the upper bound;
// a zero divisor skips the divider steps
// the result sits in an output register; the next request is taken once the
// lookup has handed its result to that register
// reset is synchronous active high; memory contents are not cleared
module hashed_key_bucket_lookup (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  hkbl_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output hkbl_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [31:0]       csr_data
);

   logic              req_fire;
   logic              idle;
   logic              miss_ff, miss_in;
   logic [31:0]       divisor_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   hkbl_pkg::rsp_type rsp_ff, rsp_in;
   hkbl_pkg::rsp_type result;
   hkbl_pkg::cmd_type ctl;
   hkbl_pkg::sts_type sts, sts_dp;

   assign req_stall = !idle;
   assign req_fire  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // divisor register
   always_ff @(posedge clock) begin
      if (reset) begin
         divisor_ff <= hkbl_pkg::DIVISOR_RESET;
      end else if (csr_valid && csr_ready) begin
         divisor_ff <= csr_data;
      end
   end

   // empty range or exhausted scan means no match
   always_comb begin
      miss_in = miss_ff;
      if (ctl.set_range || ctl.capture) begin
         miss_in = 1'b0;
      end else if (ctl.cmp == 1'b0 && ctl.rd_rec == 1'b0 && sts_dp.range_end &&
                   !idle && !ctl.div_step && !ctl.rd_lo && !ctl.rd_hi) begin
         miss_in = 1'b1;
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         miss_ff <= 1'b0;
      end else begin
         miss_ff <= miss_in;
      end
   end

   assign sts.div_done  = sts_dp.div_done;
   assign sts.range_end = sts_dp.range_end;
   assign sts.hit       = sts_dp.hit;

   hkbl_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req        (req_data),
      .req_fire   (req_fire),
      .divisor    (divisor_ff),
      .ctl        (ctl),
      .sts        (sts_dp),
      .rsp_result (result)
   );

   hkbl_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_fire (req_fire),
      .req_cmd  (req_data.cmd),
      .rsp_busy (rsp_valid_ff && rsp_stall),
      .sts      (sts),
      .ctl      (ctl),
      .idle     (idle)
   );

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      if (ctl.load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_in       = miss_ff ? '0 : result;
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // checks
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      ctl.load_rsp |-> (rsp_valid_ff == 1'b0 || rsp_stall == 1'b0))
      else $error("result register overwritten while stalled");
   a_capture_idle: assert property (@(posedge clock) disable iff (reset)
      ctl.capture |-> idle)
      else $error("lookup started while busy");
   a_found_id: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.found) |-> (rsp_data.doc_id != 32'd0))
      else $error("found set with zero id");
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      ctl.rd_lo |-> sts.div_done)
      else $error("bound read before quotient ready");

endmodule
